/* hdl/sslp_pkg.sv */
// Shared types, constants and helper functions for the servo slew limiter.
// Used by every module of the block; depends on nothing else.

package sslp_pkg;

   localparam int CHANNELS_DEF      = 6;
   localparam int ANGLE_SPAN_DEF    = 178;
   localparam int FRACTION_BITS_DEF = 4;

   localparam int ANGLE_W = 12;
   localparam int COUNT_W = 12;
   localparam int CHAN_W  = 3;
   localparam int ADDR_W  = 7;
   localparam int CSR_AW  = 4;
   localparam int CSR_DW  = 32;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 12'hFFF;
   localparam logic [ADDR_W-1:0]  REG_BASE  = 7'h1A;

   localparam logic [COUNT_W-1:0] STEP_SIZE_RST   = 12'd80;
   localparam logic [COUNT_W-1:0] PULSE_MIN_RST   = 12'd108;
   localparam logic [COUNT_W-1:0] PULSE_MAX_RST   = 12'd533;
   localparam logic [COUNT_W-1:0] PULSE_DELAY_RST = 12'd100;

   localparam int QUEUE_DEPTH = 2;

   // start pose in millidegrees, one entry per possible channel
   localparam int POSE_MDEG [16] = '{90000, 2317, 3798, 151481, 90000, 0, 0, 0,
                                     0, 0, 0, 0, 0, 0, 0, 0};

   typedef enum logic [1:0] {
      CSR_STEP_SIZE   = 2'd0,
      CSR_PULSE_MIN   = 2'd1,
      CSR_PULSE_MAX   = 2'd2,
      CSR_PULSE_DELAY = 2'd3
   } csr_index_type;

   typedef enum logic {
      CMD_SET_TARGET = 1'b0,
      CMD_TICK       = 1'b1
   } command_type;

   typedef enum logic {
      SCAN_IDLE,
      SCAN_RUN
   } scan_state_type;

   typedef struct packed {
      command_type         command;
      logic [CHAN_W-1:0]   channel;
      logic [ANGLE_W-1:0]  angle;
   } entry_type;

   typedef struct packed {
      logic                write;
      logic [CHAN_W-1:0]   channel;
      logic                last;
      logic                settled;
   } tag_type;

   typedef struct packed {
      tag_type             tag;
      logic [ANGLE_W-1:0]  angle;
   } issue_type;

   // largest legal angle in fixed-point units
   function automatic logic [ANGLE_W-1:0] span_limit(input int span, input int fb);
      longint s;
      s = longint'(span) << fb;
      return (s > 4095) ? COUNT_MAX : ANGLE_W'(s);
   endfunction

   // start pose of one channel, rounded to fixed point and clamped to the span
   function automatic logic [ANGLE_W-1:0] pose_angle(input int ch, input int span,
                                                      input int fb);
      longint              m;
      longint              v;
      logic [ANGLE_W-1:0]  lim;
      m   = longint'(POSE_MDEG[ch & 15]);
      v   = ((m << fb) + 500) / 1000;
      lim = span_limit(span, fb);
      if (v > longint'(lim)) v = longint'(lim);
      return ANGLE_W'(v);
   endfunction

endpackage

/* hdl/servo_slew_limiter_pwm.sv */
// Top level of the servo slew limiter: register file, front end, queue,
// channel scanner and pulse pipeline. Depends on sslp_pkg and all sslp_ modules.
//
// Use: the request channel (req_) carries set-target and tick beats. A set-target
// beat loads one channel's target (clamped to the span) and gives no result; a
// beat for a channel that does not exist is taken and dropped. A tick beat moves
// every channel that is off target by at most step_size and gives one result
// beat per moved channel, in channel order, with last on the final one and
// all_settled on all of them if every channel ends on target; a tick that moves
// nothing gives one result with write_valid low and last and all_settled high.
// Path: queue entry, scanner issue register, pulse stages a, b and c, result register.
// A moving channel is issued only once the scan reaches its index. A tick holds the
// scanner until it has walked the channels up to the highest moving one; a set-target
// beat is applied as the scanner takes it. The scanner sets the rate.
// Requests are queued two deep, so new beats are taken while results wait.
// Stall: when the result channel stalls, the result register holds its beat and
// the whole back end holds; the front stalls only once the queue fills.
// Reset: synchronous; restores the start pose for current and target angles and
// the default register values, and empties the queue and the pipeline.
// Registers (APB, 4 bytes apart): step_size, pulse_min, pulse_max, pulse_delay.

module servo_slew_limiter_pwm #(
   parameter int CHANNELS      = sslp_pkg::CHANNELS_DEF,
   parameter int ANGLE_SPAN    = sslp_pkg::ANGLE_SPAN_DEF,
   parameter int FRACTION_BITS = sslp_pkg::FRACTION_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [sslp_pkg::CSR_AW-1:0]   paddr,
   input  logic [sslp_pkg::CSR_DW-1:0]   pwdata,
   output logic [sslp_pkg::CSR_DW-1:0]   prdata,
   output logic                          pready,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_command,
   input  logic [sslp_pkg::CHAN_W-1:0]   req_channel,
   input  logic [sslp_pkg::ANGLE_W-1:0]  req_target_angle,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_write_valid,
   output logic [sslp_pkg::CHAN_W-1:0]   rsp_channel_out,
   output logic [sslp_pkg::ADDR_W-1:0]   rsp_register_address,
   output logic [sslp_pkg::COUNT_W-1:0]  rsp_on_count,
   output logic [sslp_pkg::COUNT_W-1:0]  rsp_off_count,
   output logic                          rsp_last,
   output logic                          rsp_all_settled
);
   import sslp_pkg::*;

   // register file
   logic [COUNT_W-1:0] step_size_ff, step_size_in;
   logic [COUNT_W-1:0] pulse_min_ff, pulse_min_in;
   logic [COUNT_W-1:0] pulse_max_ff, pulse_max_in;
   logic [COUNT_W-1:0] pulse_delay_ff, pulse_delay_in;
   logic [COUNT_W-1:0] step_eff;
   logic [COUNT_W-1:0] rd_value;
   logic               csr_write;
   csr_index_type      csr_index;

   // front to back
   logic       push;
   entry_type  push_entry;
   logic       queue_full;
   logic       queue_empty;
   entry_type  head;
   logic       pop;
   logic       adv;
   logic       issue_valid;
   issue_type  issue;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = csr_index_type'(paddr[3:2]);

   always_comb begin
      step_size_in   = step_size_ff;
      pulse_min_in   = pulse_min_ff;
      pulse_max_in   = pulse_max_ff;
      pulse_delay_in = pulse_delay_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_STEP_SIZE:   step_size_in   = pwdata[COUNT_W-1:0];
            CSR_PULSE_MIN:   pulse_min_in   = pwdata[COUNT_W-1:0];
            CSR_PULSE_MAX:   pulse_max_in   = pwdata[COUNT_W-1:0];
            CSR_PULSE_DELAY: pulse_delay_in = pwdata[COUNT_W-1:0];
            default:         step_size_in   = step_size_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_STEP_SIZE:   rd_value = step_size_ff;
         CSR_PULSE_MIN:   rd_value = pulse_min_ff;
         CSR_PULSE_MAX:   rd_value = pulse_max_ff;
         CSR_PULSE_DELAY: rd_value = pulse_delay_ff;
         default:         rd_value = '0;
      endcase
   end

   assign prdata = CSR_DW'(rd_value);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_size_ff   <= STEP_SIZE_RST;
         pulse_min_ff   <= PULSE_MIN_RST;
         pulse_max_ff   <= PULSE_MAX_RST;
         pulse_delay_ff <= PULSE_DELAY_RST;
      end else begin
         step_size_ff   <= step_size_in;
         pulse_min_ff   <= pulse_min_in;
         pulse_max_ff   <= pulse_max_in;
         pulse_delay_ff <= pulse_delay_in;
      end
   end

   // a zero step would never reach the target: treat it as one
   assign step_eff = (step_size_ff == '0) ? COUNT_W'(1) : step_size_ff;

   // classify and clamp incoming beats
   sslp_front #(
      .CHANNELS      (CHANNELS),
      .ANGLE_SPAN    (ANGLE_SPAN),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_front (
      .req_valid        (req_valid),
      .req_command      (req_command),
      .req_channel      (req_channel),
      .req_target_angle (req_target_angle),
      .queue_full       (queue_full),
      .req_stall        (req_stall),
      .push             (push),
      .push_entry       (push_entry)
   );

   // decouple the front from the back end
   sslp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .empty      (queue_empty),
      .head       (head)
   );

   // apply targets and walk the channels on a tick
   sslp_scan #(
      .CHANNELS      (CHANNELS),
      .ANGLE_SPAN    (ANGLE_SPAN),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .empty       (queue_empty),
      .head        (head),
      .step        (step_eff),
      .pop         (pop),
      .issue_valid (issue_valid),
      .issue       (issue)
   );

   // angle to pulse counts, ending in the result register
   sslp_pulse #(
      .ANGLE_SPAN    (ANGLE_SPAN),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_pulse (
      .clock                (clock),
      .reset                (reset),
      .issue_valid          (issue_valid),
      .issue                (issue),
      .pulse_min            (pulse_min_ff),
      .pulse_max            (pulse_max_ff),
      .pulse_delay          (pulse_delay_ff),
      .rsp_stall            (rsp_stall),
      .adv                  (adv),
      .rsp_valid            (rsp_valid),
      .rsp_write_valid      (rsp_write_valid),
      .rsp_channel_out      (rsp_channel_out),
      .rsp_register_address (rsp_register_address),
      .rsp_on_count         (rsp_on_count),
      .rsp_off_count        (rsp_off_count),
      .rsp_last             (rsp_last),
      .rsp_all_settled      (rsp_all_settled)
   );

   // a beat without a write only closes a tick that moved nothing
   a_null_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_valid |-> rsp_last && rsp_all_settled)
      else $error("result without write lacks last or settled flag");

   // a write always targets the pulse registers of its own channel
   a_reg_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_write_valid |->
         rsp_register_address == REG_BASE + ADDR_W'({rsp_channel_out, 2'b00}))
      else $error("pulse register address does not match channel");

   // the off count never falls before the on count
   a_off_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_write_valid |-> rsp_off_count >= rsp_on_count)
      else $error("off count below on count");

endmodule

/* hdl/sslp_front.sv */
// Front end: takes request beats, clamps targets and drops useless items.
// Depends on sslp_pkg.

module sslp_front #(
   parameter int CHANNELS      = sslp_pkg::CHANNELS_DEF,
   parameter int ANGLE_SPAN    = sslp_pkg::ANGLE_SPAN_DEF,
   parameter int FRACTION_BITS = sslp_pkg::FRACTION_BITS_DEF
) (
   input  logic                           req_valid,
   input  logic                           req_command,
   input  logic [sslp_pkg::CHAN_W-1:0]    req_channel,
   input  logic [sslp_pkg::ANGLE_W-1:0]   req_target_angle,
   input  logic                           queue_full,
   output logic                           req_stall,
   output logic                           push,
   output sslp_pkg::entry_type            push_entry
);
   import sslp_pkg::*;

   localparam logic [ANGLE_W-1:0] LIMIT = span_limit(ANGLE_SPAN, FRACTION_BITS);

   logic is_tick;
   logic chan_ok;

   assign is_tick   = (command_type'(req_command) == CMD_TICK);
   assign chan_ok   = (32'(req_channel) < CHANNELS);
   assign req_stall = queue_full;

   // a set-target beat for a missing channel is taken and dropped here
   assign push = req_valid && !queue_full && (is_tick || chan_ok);

   always_comb begin
      push_entry.command = command_type'(req_command);
      push_entry.channel = req_channel;
      push_entry.angle   = (req_target_angle > LIMIT) ? LIMIT : req_target_angle;
   end

endmodule

/* hdl/sslp_queue.sv */
// Short command queue between the front end and the channel scanner.
// Depends on sslp_pkg.

module sslp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sslp_pkg::entry_type  push_entry,
   input  logic                 pop,
   output logic                 full,
   output logic                 empty,
   output sslp_pkg::entry_type  head
);
   import sslp_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   entry_type        mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign full  = (count_ff == CW'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* hdl/sslp_scan.sv */
// Back end sequencer: holds current and target angles, applies set-target
// commands; on a tick walks the channels one per unstalled cycle. Uses sslp_pkg.

module sslp_scan #(
   parameter int CHANNELS      = sslp_pkg::CHANNELS_DEF,
   parameter int ANGLE_SPAN    = sslp_pkg::ANGLE_SPAN_DEF,
   parameter int FRACTION_BITS = sslp_pkg::FRACTION_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          empty,
   input  sslp_pkg::entry_type           head,
   input  logic [sslp_pkg::ANGLE_W-1:0]  step,
   output logic                          pop,
   output logic                          issue_valid,
   output sslp_pkg::issue_type           issue
);
   import sslp_pkg::*;

   localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   scan_state_type        state_ff, state_in;
   logic [ANGLE_W-1:0]    cur_ff [CHANNELS];
   logic [ANGLE_W-1:0]    tgt_ff [CHANNELS];
   logic [CHANNELS-1:0]   mask_ff, mask_in;
   logic                  settled_ff, settled_in;
   logic [IW-1:0]         idx_ff, idx_in;
   logic                  issue_valid_ff, issue_valid_in;
   issue_type             issue_ff, issue_in;

   logic [CHANNELS-1:0]   moving;
   logic [CHANNELS-1:0]   close;
   logic                  any_moving;
   logic                  head_tick;
   logic                  set_wr;
   logic                  cur_wr;
   logic [CHANNELS-1:0]   rest;
   logic                  at_end;
   logic [ANGLE_W-1:0]    cur_sel;
   logic [ANGLE_W-1:0]    tgt_sel;
   logic                  up;
   logic [ANGLE_W-1:0]    gap;
   logic [ANGLE_W-1:0]    next_angle;

   // per-channel move and settle flags, all lanes in parallel
   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         moving[i] = (cur_ff[i] != tgt_ff[i]);
         close[i]  = ((cur_ff[i] > tgt_ff[i]) ? (cur_ff[i] - tgt_ff[i])
                                              : (tgt_ff[i] - cur_ff[i])) <= step;
      end
   end

   assign any_moving = |moving;
   assign head_tick  = (head.command == CMD_TICK);
   assign rest       = mask_ff >> idx_ff;
   assign at_end     = ((rest >> 1) == '0);

   assign cur_sel    = cur_ff[idx_ff];
   assign tgt_sel    = tgt_ff[idx_ff];
   assign up         = (tgt_sel > cur_sel);
   assign gap        = up ? (tgt_sel - cur_sel) : (cur_sel - tgt_sel);
   assign next_angle = (gap > step) ? (up ? cur_sel + step : cur_sel - step) : tgt_sel;

   always_comb begin : next_state
      state_in = state_ff;
      case (state_ff)
         SCAN_IDLE: begin
            if (adv && !empty && head_tick && any_moving) state_in = SCAN_RUN;
         end
         SCAN_RUN: begin
            if (adv && at_end) state_in = SCAN_IDLE;
         end
         default: state_in = SCAN_IDLE;
      endcase
   end

   always_comb begin : outputs
      pop            = 1'b0;
      set_wr         = 1'b0;
      cur_wr         = 1'b0;
      mask_in        = mask_ff;
      settled_in     = settled_ff;
      idx_in         = idx_ff;
      issue_valid_in = issue_valid_ff;
      issue_in       = issue_ff;
      case (state_ff)
         SCAN_IDLE: begin
            if (adv) begin
               issue_valid_in = 1'b0;
               if (!empty) begin
                  pop = 1'b1;
                  if (!head_tick) begin
                     set_wr = 1'b1;
                  end else if (any_moving) begin
                     mask_in    = moving;
                     settled_in = &close;
                     idx_in     = '0;
                  end else begin
                     // nothing moves: one empty result marks the tick done
                     issue_valid_in       = 1'b1;
                     issue_in.tag.write   = 1'b0;
                     issue_in.tag.channel = '0;
                     issue_in.tag.last    = 1'b1;
                     issue_in.tag.settled = 1'b1;
                     issue_in.angle       = '0;
                  end
               end
            end
         end
         SCAN_RUN: begin
            if (adv) begin
               issue_valid_in = rest[0];
               cur_wr         = rest[0];
               issue_in.tag.write   = 1'b1;
               issue_in.tag.channel = CHAN_W'(idx_ff);
               issue_in.tag.last    = at_end;
               issue_in.tag.settled = settled_ff;
               issue_in.angle       = next_angle;
               idx_in               = idx_ff + 1'b1;
            end
         end
         default: begin
            issue_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= SCAN_IDLE;
         mask_ff        <= '0;
         settled_ff     <= 1'b0;
         idx_ff         <= '0;
         issue_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            cur_ff[i] <= pose_angle(i, ANGLE_SPAN, FRACTION_BITS);
            tgt_ff[i] <= pose_angle(i, ANGLE_SPAN, FRACTION_BITS);
         end
      end else begin
         state_ff       <= state_in;
         mask_ff        <= mask_in;
         settled_ff     <= settled_in;
         idx_ff         <= idx_in;
         issue_valid_ff <= issue_valid_in;
         if (set_wr) begin
            tgt_ff[IW'(head.channel)] <= head.angle;
         end
         if (cur_wr) begin
            cur_ff[idx_ff] <= next_angle;
         end
      end
   end

   always_ff @(posedge clock) begin
      issue_ff <= issue_in;
   end

   assign issue_valid = issue_valid_ff;
   assign issue       = issue_ff;

endmodule

/* hdl/sslp_pulse.sv */
// Pulse pipeline: maps each stepped angle to on/off counts over four stages
// and holds the result beat in the output register. Depends on sslp_pkg.

module sslp_pulse #(
   parameter int ANGLE_SPAN    = sslp_pkg::ANGLE_SPAN_DEF,
   parameter int FRACTION_BITS = sslp_pkg::FRACTION_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          issue_valid,
   input  sslp_pkg::issue_type           issue,
   input  logic [sslp_pkg::COUNT_W-1:0]  pulse_min,
   input  logic [sslp_pkg::COUNT_W-1:0]  pulse_max,
   input  logic [sslp_pkg::COUNT_W-1:0]  pulse_delay,
   input  logic                          rsp_stall,
   output logic                          adv,
   output logic                          rsp_valid,
   output logic                          rsp_write_valid,
   output logic [sslp_pkg::CHAN_W-1:0]   rsp_channel_out,
   output logic [sslp_pkg::ADDR_W-1:0]   rsp_register_address,
   output logic [sslp_pkg::COUNT_W-1:0]  rsp_on_count,
   output logic [sslp_pkg::COUNT_W-1:0]  rsp_off_count,
   output logic                          rsp_last,
   output logic                          rsp_all_settled
);
   import sslp_pkg::*;

   // rounded quotient (2*mag + DEN) / (2*DEN) by reciprocal and one correction
   localparam int     DEN     = ANGLE_SPAN << FRACTION_BITS;
   localparam int     D2      = 2 * DEN;
   localparam int     DW      = $clog2(D2 + 1);
   localparam int     MW      = ANGLE_W + COUNT_W;
   localparam int     NW      = MW + 2;
   localparam int     SH      = NW;
   localparam int     RW      = SH;
   localparam int     PW      = NW + RW;
   localparam int     QW      = NW + DW;
   localparam int     WW      = NW + 2;
   localparam longint RECIP_L = (longint'(1) << SH) / D2;

   localparam logic [RW-1:0] RECIP = RW'(RECIP_L);
   localparam logic [DW-1:0] D2_V  = DW'(D2);
   localparam logic [NW-1:0] DEN_V = NW'(DEN);

   logic                 neg;
   logic [COUNT_W-1:0]   absdiff;

   logic                 va_ff, vb_ff, vc_ff;
   tag_type              taga_ff, tagb_ff, tagc_ff;
   logic                 nega_ff, negb_ff, negc_ff;
   logic [MW-1:0]        mag_ff;
   logic [NW-1:0]        n_in;
   logic [NW-1:0]        nb_ff, nc_ff;
   logic [PW-1:0]        nr_ff;
   logic [NW-1:0]        qe_in;
   logic [NW-1:0]        qe_ff;
   logic [QW-1:0]        qd_ff;

   logic [QW-1:0]        rem;
   logic [NW-1:0]        quot;
   logic signed [WW-1:0] width;
   logic [WW-1:0]        off_sum;
   logic [COUNT_W-1:0]   off_sat;

   logic                 rsp_valid_ff;
   tag_type              rsp_tag_ff;
   logic [ADDR_W-1:0]    rsp_addr_ff;
   logic [COUNT_W-1:0]   rsp_on_ff;
   logic [COUNT_W-1:0]   rsp_off_ff;

   assign adv     = !rsp_valid_ff || !rsp_stall;
   assign neg     = (pulse_max < pulse_min);
   assign absdiff = neg ? (pulse_min - pulse_max) : (pulse_max - pulse_min);

   assign n_in  = {mag_ff, 1'b0} + DEN_V;
   assign qe_in = NW'(nr_ff >> SH);

   // final stage: correct the quotient, apply sign, clamp and saturate
   assign rem     = QW'(nc_ff) - qd_ff;
   assign quot    = (rem >= QW'(D2_V)) ? qe_ff + 1'b1 : qe_ff;
   assign width   = negc_ff ? ($signed(WW'(pulse_min)) - $signed(WW'(quot)))
                            : ($signed(WW'(pulse_min)) + $signed(WW'(quot)));
   assign off_sum = (width < 0) ? WW'(pulse_delay) : (WW'(width) + WW'(pulse_delay));
   assign off_sat = (off_sum > WW'(COUNT_MAX)) ? COUNT_MAX : off_sum[COUNT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff        <= 1'b0;
         vb_ff        <= 1'b0;
         vc_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         va_ff        <= issue_valid;
         vb_ff        <= va_ff;
         vc_ff        <= vb_ff;
         rsp_valid_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         taga_ff <= issue.tag;
         nega_ff <= neg;
         mag_ff  <= MW'(issue.angle) * MW'(absdiff);

         tagb_ff <= taga_ff;
         negb_ff <= nega_ff;
         nb_ff   <= n_in;
         nr_ff   <= PW'(n_in) * PW'(RECIP);

         tagc_ff <= tagb_ff;
         negc_ff <= negb_ff;
         nc_ff   <= nb_ff;
         qe_ff   <= qe_in;
         qd_ff   <= QW'(qe_in) * QW'(D2_V);

         rsp_tag_ff  <= tagc_ff;
         rsp_addr_ff <= tagc_ff.write ? REG_BASE + ADDR_W'({tagc_ff.channel, 2'b00}) : '0;
         rsp_on_ff   <= tagc_ff.write ? pulse_delay : '0;
         rsp_off_ff  <= tagc_ff.write ? off_sat : '0;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_write_valid      = rsp_tag_ff.write;
   assign rsp_channel_out      = rsp_tag_ff.write ? rsp_tag_ff.channel : '0;
   assign rsp_register_address = rsp_addr_ff;
   assign rsp_on_count         = rsp_on_ff;
   assign rsp_off_count        = rsp_off_ff;
   assign rsp_last             = rsp_tag_ff.last;
   assign rsp_all_settled      = rsp_tag_ff.settled;

endmodule
